[hw/rtl/mqtt_receive_deframer_assert.svh]
// ----------------------------------------------------------------------------
// mqtt_receive_deframer_assert.svh
// Assertion macros shared by the deframer's checker.
// ----------------------------------------------------------------------------
`ifndef MQTT_RECEIVE_DEFRAMER_ASSERT_SVH
`define MQTT_RECEIVE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define MRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, off while in reset.
`define MRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

[hw/rtl/mrd_pkg.sv]
// ----------------------------------------------------------------------------
// mrd_pkg
// Types and codes of the MQTT receive deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

	// input actions
	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_DROP    = 2'd1;
	localparam logic [1:0] ACT_CONNECT = 2'd2;

	// parser phases
	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_SKIP    = 3'd2;
	localparam logic [2:0] PH_HEAD    = 3'd3;
	localparam logic [2:0] PH_TOPIC   = 3'd4;
	localparam logic [2:0] PH_MESSAGE = 3'd5;
	localparam logic [2:0] PH_DROP    = 3'd6;

	// link states
	localparam logic [1:0] LINK_DOWN = 2'd0;
	localparam logic [1:0] LINK_UP   = 2'd1;
	localparam logic [1:0] LINK_LIVE = 2'd2;

	// result kinds
	localparam logic [2:0] K_TOPIC   = 3'd0;
	localparam logic [2:0] K_MESSAGE = 3'd1;
	localparam logic [2:0] K_EMPTY   = 3'd2;
	localparam logic [2:0] K_STATE   = 3'd3;
	localparam logic [2:0] K_MALFORM = 3'd4;

	// packet types
	localparam logic [3:0] PT_CONNACK = 4'd2;
	localparam logic [3:0] PT_PUBLISH = 4'd3;

	localparam int unsigned LEN_W   = 28;
	localparam int unsigned TOPIC_W = 16;
	localparam int unsigned MAX_DIGITS = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
		logic [1:0] link_state;
	} result_t;

endpackage

[hw/rtl/mrd_if.sv]
// ----------------------------------------------------------------------------
// mrd_if
// Valid/ready channels of the deframer: input items and results.
// ----------------------------------------------------------------------------
interface mrd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface mrd_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data;
	logic       last;
	logic [1:0] link_state;

	modport source (output valid, output kind, output data, output last, output link_state,
		input ready);
	modport sink (input valid, input kind, input data, input last, input link_state,
		output ready);
endinterface

[hw/rtl/mqtt_receive_deframer.sv]
// An accepted word is held in the input register; its result then goes to the output register or the skid word.
// Throughput: one word per cycle while the skid word is empty; the parser state updates once per word.
// Results wait in an output register plus one skid word; once the skid word is taken,
// the input register stops advancing (for every word, with or without a result) until the result side drains.
// Reset (arst_n low, asynchronous): link disconnected, parser expects a header byte,
// input and output registers empty.
// ----------------------------------------------------------------------------
// mqtt_receive_deframer
// Decodes MQTT fixed headers from received bytes and streams publish payloads.
// ----------------------------------------------------------------------------
module mqtt_receive_deframer
	import mrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mrd_item_if.sink     items,
	mrd_result_if.source results
);

	logic    s1_valid_q;
	item_t   item_s1;
	logic    room;
	logic    advance;
	logic    accept;
	logic    res_valid;
	result_t res;

	assign advance     = s1_valid_q && room;
	assign items.ready = !s1_valid_q || room;
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (advance)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action  <= items.action;
			item_s1.rx_byte <= items.rx_byte;
		end
	end

	mrd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mrd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_data (res),
		.room      (room),
		.results   (results)
	);

endmodule

[hw/rtl/mrd_parser.sv]
// ----------------------------------------------------------------------------
// mrd_parser
// Fixed-header parser state and its combinational next-state and result logic.
// ----------------------------------------------------------------------------
module mrd_parser
	import mrd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	logic [2:0]         phase_q, phase_d;
	logic [3:0]         ptype_q, ptype_d;
	logic [LEN_W-1:0]   accum_q, accum_d;
	logic [2:0]         digits_q, digits_d;
	logic [LEN_W-1:0]   body_left_q, body_left_d;
	logic [TOPIC_W-1:0] topic_left_q, topic_left_d;
	logic               body_idx_q, body_idx_d;
	logic [1:0]         link_q, link_d;

	logic [LEN_W-1:0]   body_dec;
	logic [TOPIC_W-1:0] topic_dec;
	logic [TOPIC_W-1:0] topic_full;
	logic [LEN_W-1:0]   accum_new;
	logic [7:0]         b;

	assign b          = item.rx_byte;
	assign body_dec   = body_left_q - LEN_W'(1);
	assign topic_dec  = topic_left_q - TOPIC_W'(1);
	assign topic_full = {topic_left_q[15:8], b};

	// place the next base-128 digit, least significant first
	always_comb begin
		case (digits_q[1:0])
			2'd0:    accum_new = accum_q | {21'd0, b[6:0]};
			2'd1:    accum_new = accum_q | {14'd0, b[6:0], 7'd0};
			2'd2:    accum_new = accum_q | {7'd0, b[6:0], 14'd0};
			default: accum_new = accum_q | {b[6:0], 21'd0};
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		ptype_d      = ptype_q;
		accum_d      = accum_q;
		digits_d     = digits_q;
		body_left_d  = body_left_q;
		topic_left_d = topic_left_q;
		body_idx_d   = body_idx_q;
		link_d       = link_q;
		res_valid    = 1'b0;
		res.kind     = K_STATE;
		res.data     = 8'd0;
		res.last     = 1'b0;

		case (item.action)
			ACT_DROP: begin
				phase_d      = PH_HEADER;
				ptype_d      = 4'd0;
				accum_d      = '0;
				digits_d     = 3'd0;
				body_left_d  = '0;
				topic_left_d = '0;
				body_idx_d   = 1'b0;
				link_d       = LINK_DOWN;
				res_valid    = 1'b1;
			end
			ACT_CONNECT: begin
				if (link_q == LINK_DOWN) begin
					link_d    = LINK_UP;
					res_valid = 1'b1;
				end
			end
			ACT_BYTE: begin
				case (phase_q)
					PH_LENGTH: begin
						accum_d  = accum_new;
						digits_d = digits_q + 3'd1;
						if (b[7]) begin
							if (digits_d >= 3'(MAX_DIGITS)) begin
								phase_d   = PH_DROP;
								res_valid = 1'b1;
								res.kind  = K_MALFORM;
							end
						end else begin
							body_left_d = accum_new;
							body_idx_d  = 1'b0;
							if (accum_new == '0)
								phase_d = PH_HEADER;
							else if (accum_new < LEN_W'(2) ||
								!(ptype_q inside {PT_CONNACK, PT_PUBLISH}))
								phase_d = PH_SKIP;
							else
								phase_d = PH_HEAD;
						end
					end
					PH_SKIP: begin
						body_left_d = body_dec;
						if (body_dec == '0)
							phase_d = PH_HEADER;
					end
					PH_HEAD: begin
						body_left_d = body_dec;
						if (!body_idx_q) begin
							topic_left_d = {b, 8'd0};
							body_idx_d   = 1'b1;
						end else begin
							body_idx_d = 1'b0;
							if (ptype_q == PT_CONNACK) begin
								link_d    = (b == 8'd0) ? LINK_LIVE : LINK_DOWN;
								phase_d   = (body_dec == '0) ? PH_HEADER : PH_SKIP;
								res_valid = 1'b1;
							end else if (LEN_W'(topic_full) > body_dec) begin
								// topic runs past the body: skip the rest
								topic_left_d = '0;
								phase_d      = (body_dec == '0) ? PH_HEADER : PH_SKIP;
							end else if (body_dec == '0) begin
								topic_left_d = topic_full;
								phase_d      = PH_HEADER;
								res_valid    = 1'b1;
								res.kind     = K_EMPTY;
								res.last     = 1'b1;
							end else begin
								topic_left_d = topic_full;
								phase_d      = (topic_full != '0) ? PH_TOPIC : PH_MESSAGE;
							end
						end
					end
					PH_TOPIC: begin
						body_left_d  = body_dec;
						topic_left_d = topic_dec;
						if (body_dec == '0)
							phase_d = PH_HEADER;
						else if (topic_dec == '0)
							phase_d = PH_MESSAGE;
						res_valid = 1'b1;
						res.kind  = K_TOPIC;
						res.data  = b;
						res.last  = (body_dec == '0);
					end
					PH_MESSAGE: begin
						body_left_d = body_dec;
						if (body_dec == '0)
							phase_d = PH_HEADER;
						res_valid = 1'b1;
						res.kind  = K_MESSAGE;
						res.data  = b;
						res.last  = (body_dec == '0);
					end
					PH_DROP: begin
						// hold until the link drops
					end
					default: begin
						ptype_d  = b[7:4];
						accum_d  = '0;
						digits_d = 3'd0;
						phase_d  = PH_LENGTH;
					end
				endcase
			end
			default: begin
			end
		endcase

		res.link_state = link_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			ptype_q      <= 4'd0;
			accum_q      <= '0;
			digits_q     <= 3'd0;
			body_left_q  <= '0;
			topic_left_q <= '0;
			body_idx_q   <= 1'b0;
			link_q       <= LINK_DOWN;
		end else if (step) begin
			phase_q      <= phase_d;
			ptype_q      <= ptype_d;
			accum_q      <= accum_d;
			digits_q     <= digits_d;
			body_left_q  <= body_left_d;
			topic_left_q <= topic_left_d;
			body_idx_q   <= body_idx_d;
			link_q       <= link_d;
		end
	end

endmodule

[hw/rtl/mrd_out_buf.sv]
// ----------------------------------------------------------------------------
// mrd_out_buf
// Result register with a skid stage in front of the result channel.
// ----------------------------------------------------------------------------
module mrd_out_buf
	import mrd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	mrd_result_if.source results
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign room = !skid_valid_q;
	assign pop  = out_valid_q && results.ready;

	assign results.valid      = out_valid_q;
	assign results.kind       = out_q.kind;
	assign results.data       = out_q.data;
	assign results.last       = out_q.last;
	assign results.link_state = out_q.link_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			// skid holds the older word, so it goes first
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_data;
		end else if (push) begin
			if (out_valid_q)
				skid_q <= push_data;
			else
				out_q <= push_data;
		end
	end

endmodule

[hw/rtl/mrd_checker.sv]
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the deframer, bound to its top level.
// ----------------------------------------------------------------------------
`include "mqtt_receive_deframer_assert.svh"

module mrd_checker
	import mrd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] kind,
	input logic [7:0] data,
	input logic       last,
	input logic [1:0] link_state
);

	`MRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({kind, data, last, link_state}))
	`MRD_ASSERT_NOW(a_kind_range, clk, arst_n, out_valid, kind <= K_MALFORM)
	`MRD_ASSERT_NOW(a_no_byte_kinds, clk, arst_n, out_valid && (kind == K_STATE || kind == K_MALFORM || kind == K_EMPTY), data == 8'd0 && last == (kind == K_EMPTY))
	`MRD_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid)

endmodule

bind mqtt_receive_deframer mrd_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.kind       (results.kind),
	.data       (results.data),
	.last       (results.last),
	.link_state (results.link_state)
);
